### src/cacss_pkg.sv
// ----------------------------------------------------------------------------
// cacss_pkg
// Shared types, constants and helpers for the cave smoothing step.
// ----------------------------------------------------------------------------
package cacss_pkg;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam int SIZE_W  = 7;
	localparam int THR_W   = 4;
	localparam int COORD_W = 6;
	localparam int CNT_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] GRID_ROWS_RST     = 7'd64;
	localparam logic [SIZE_W-1:0] GRID_COLS_RST     = 7'd64;
	localparam logic [THR_W-1:0]  DEAD_AT_MOST_RST  = 4'd3;
	localparam logic [THR_W-1:0]  DEAD_AT_LEAST_RST = 4'd7;
	localparam logic [SIZE_W-1:0] SIZE_MIN          = 7'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_ROWS     = 2'd0,
		CFG_GRID_COLS     = 2'd1,
		CFG_DEAD_AT_MOST  = 2'd2,
		CFG_DEAD_AT_LEAST = 2'd3
	} cfg_idx_t;

	// one window column: bit 0 top, bit 1 middle, bit 2 bottom
	typedef logic [2:0] col_t;

	function automatic logic [1:0] pop3(input col_t v);
		pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
	endfunction

endpackage

### src/cacss_linebuf.sv
// ----------------------------------------------------------------------------
// cacss_linebuf
// Two row buffers held as one two-bit-wide memory, registered read with
// write-to-read forwarding for same-address access in the same cycle.
// ----------------------------------------------------------------------------
module cacss_linebuf import cacss_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [MAX_COLS];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

### src/cacss_cell.sv
// ----------------------------------------------------------------------------
// cacss_cell
// One column of the 3x3 window: holds three bits, shifts in its neighbor's
// column and reports its wall count.
// ----------------------------------------------------------------------------
module cacss_cell import cacss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  col_t       col_in,
	output col_t       col,
	output logic [1:0] ones
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col  = col_q;
	assign ones = pop3(col_q);

endmodule

### src/cave_automaton_smoothing_step.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_step
// One synchronous smoothing pass over a raster stream of wall/floor cells.
// ----------------------------------------------------------------------------
//  channel  signals                               direction  flow
//  in       in_valid/in_stall, cell_in,            input      valid/stall
//           frame_start
//  out      out_valid/out_stall, out_row, out_col, output     valid/stall
//           new_cell, neighbour_count, frame_last
//  cfg      cfg_valid/cfg_ready, cfg_index,        input      valid/ready
//           cfg_data
//
//  One item per cycle sustained while out_stall is low. An accepted item is
//  held in stage 1 with its line buffer read, then the output register
//  holds the result. Border items retire from stage 1 without a result.
//  Reset clears positions, window and config; line buffers are not cleared.
//  in_stall rises only when stage 1 holds a result the output cannot take.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_step import cacss_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cell_in,
	input  logic                 frame_start,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_col,
	output logic                 new_cell,
	output logic [CNT_W-1:0]     neighbour_count,
	output logic                 frame_last,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	logic [SIZE_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [THR_W-1:0]  dam_q, dal_q;
	logic [RW-1:0]     rows_used;
	logic [CW-1:0]     cols_used;

	logic [RW-1:0] row_q, cur_r, r_inc, next_r;
	logic [CW-1:0] col_q, cur_c, c_inc, next_c;

	logic          in_acc;
	logic          s1_valid_q, s1_go, s1_emit, s1_last;
	logic          bit_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	logic [1:0]       rd_data;
	col_t             column, centre, left;
	logic [1:0]       ones_c, ones_l;
	logic [CNT_W-1:0] count;
	logic             out_free;

	logic                out_valid_q;
	logic [COORD_W-1:0]  out_row_q, out_col_q;
	logic                new_cell_q, frame_last_q;
	logic [CNT_W-1:0]    count_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= GRID_ROWS_RST;
			cols_cfg_q <= GRID_COLS_RST;
			dam_q      <= DEAD_AT_MOST_RST;
			dal_q      <= DEAD_AT_LEAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRID_ROWS:     rows_cfg_q <= cfg_data;
				CFG_GRID_COLS:     cols_cfg_q <= cfg_data;
				CFG_DEAD_AT_MOST:  dam_q      <= cfg_data[THR_W-1:0];
				CFG_DEAD_AT_LEAST: dal_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_cfg_q < SIZE_MIN) begin
			rows_used = RW'(3);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			rows_used = RW'(MAX_ROWS);
		end else begin
			rows_used = RW'(rows_cfg_q);
		end
		if (cols_cfg_q < SIZE_MIN) begin
			cols_used = CW'(3);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			cols_used = CW'(MAX_COLS);
		end else begin
			cols_used = CW'(cols_cfg_q);
		end
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = s1_valid_q && (!s1_emit || out_free);
	assign in_stall = s1_valid_q && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	// raster position
	always_comb begin
		cur_r = frame_start ? '0 : row_q;
		cur_c = frame_start ? '0 : col_q;
		c_inc = cur_c + CW'(1);
		r_inc = cur_r + RW'(1);
		if (c_inc >= cols_used) begin
			next_c = '0;
			next_r = (r_inc >= rows_used) ? '0 : r_inc;
		end else begin
			next_c = c_inc;
			next_r = cur_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= next_r;
			col_q <= next_c;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bit_s1 <= cell_in;
			row_s1 <= cur_r;
			col_s1 <= cur_c;
		end
	end

	cacss_linebuf #(
		.MAX_COLS (MAX_COLS)
	) u_linebuf (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data ({bit_s1, rd_data[1]}),
		.rd_en   (in_acc),
		.rd_addr (cur_c[AW-1:0]),
		.rd_data (rd_data)
	);

	assign column = {bit_s1, rd_data[1], rd_data[0]};

	cacss_cell u_cell_centre (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (s1_go),
		.col_in (column),
		.col    (centre),
		.ones   (ones_c)
	);

	cacss_cell u_cell_left (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (s1_go),
		.col_in (centre),
		.col    (left),
		.ones   (ones_l)
	);

	assign count = CNT_W'(ones_l) + CNT_W'(ones_c) + CNT_W'(pop3(column))
		- CNT_W'(centre[1]);
	assign s1_emit = (row_s1 >= RW'(2)) && (col_s1 >= CW'(2));
	assign s1_last = (row_s1 == rows_used - RW'(1)) && (col_s1 == cols_used - CW'(1));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_emit) begin
			out_row_q    <= COORD_W'(row_s1 - RW'(1));
			out_col_q    <= COORD_W'(col_s1 - CW'(1));
			new_cell_q   <= !((count <= dam_q) || (count >= dal_q));
			count_q      <= count;
			frame_last_q <= s1_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_row         = out_row_q;
	assign out_col         = out_col_q;
	assign new_cell        = new_cell_q;
	assign neighbour_count = count_q;
	assign frame_last      = frame_last_q;

endmodule

### src/cacss_check.sv
// ----------------------------------------------------------------------------
// cacss_check
// Port-level checks on the result channel of the cave smoothing step.
// ----------------------------------------------------------------------------
module cacss_check import cacss_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [COORD_W-1:0] out_row,
	input logic [COORD_W-1:0] out_col,
	input logic               new_cell,
	input logic [CNT_W-1:0]   neighbour_count,
	input logic               frame_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(new_cell) && $stable(neighbour_count) && $stable(frame_last))
		else $error("result changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> neighbour_count <= CNT_W'(8))
		else $error("neighbor count above eight");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("border cell emitted");

	a_empty_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_cell |-> neighbour_count != '0)
		else $error("wall with no neighbors");

endmodule

bind cave_automaton_smoothing_step cacss_check u_cacss_check (.*);

### sim/cave_automaton_smoothing_step_tb.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_step_tb
// Streams wall/floor grids through the smoothing step under random idling and
// output back-pressure. Every accepted cell is run through a local predictor
// of the 3x3 neighbour count and smoothing rule; each result is checked field
// by field in order. The run opens with a short table of hand-made 3x3 grids,
// then covers clamped grids of full height or width, threshold extremes, mid-grid
// restarts and mid-grid narrowing, and random sizes and thresholds.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cacss_pkg::*;

	localparam int CELL_TARGET    = 1850;
	localparam int QUIET_AFTER    = 1550;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int MAX_REPORTS    = 30;

	typedef struct packed {
		logic [COORD_W-1:0] res_row;
		logic [COORD_W-1:0] res_col;
		logic               res_wall;
		logic [CNT_W-1:0]   res_count;
		logic               res_last;
	} cell_result_t;

	typedef struct packed {
		logic         wall;
		logic         restart;
		logic         typed;
		cell_result_t want;
	} directed_row_t;

	localparam cell_result_t NO_RES     = '0;
	localparam cell_result_t ALL_WALL   = '{6'd1, 6'd1, 1'b0, 4'd8, 1'b1};
	localparam cell_result_t ALL_FLOOR  = '{6'd1, 6'd1, 1'b0, 4'd0, 1'b1};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 cell_in = 1'b0;
	logic                 frame_start = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COORD_W-1:0]   out_row;
	logic [COORD_W-1:0]   out_col;
	logic                 new_cell;
	logic [CNT_W-1:0]     neighbour_count;
	logic                 frame_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index = CFG_GRID_ROWS;
	logic [SIZE_W-1:0]    cfg_data = '0;

	cave_automaton_smoothing_step dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cell_in         (cell_in),
		.frame_start     (frame_start),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_row         (out_row),
		.out_col         (out_col),
		.new_cell        (new_cell),
		.neighbour_count (neighbour_count),
		.frame_last      (frame_last),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [SIZE_W-1:0] rows_reg = GRID_ROWS_RST;
	logic [SIZE_W-1:0] cols_reg = GRID_COLS_RST;
	logic [THR_W-1:0]  floor_most_reg = DEAD_AT_MOST_RST;
	logic [THR_W-1:0]  floor_least_reg = DEAD_AT_LEAST_RST;
	bit                older_line [MAX_COLS_DEF];
	bit                newer_line [MAX_COLS_DEF];
	logic [5:0]        window_cols = '0;
	int                row_pos = 0;
	int                col_pos = 0;

	cell_result_t  pending_cells [$];
	directed_row_t directed_rows [20];

	int cells_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int phases_run = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	int cols_in_use = MAX_COLS_DEF;
	bit idling_on = 1'b1;

	function automatic int clamp_size(input int v, input int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit smooth_cell(input logic wall, input logic restart,
			output cell_result_t res);
		int         rows_used;
		int         cols_used;
		int         r;
		int         c;
		int         cnt;
		logic [2:0] left;
		logic [2:0] centre;
		logic [2:0] column;
		bit         hit;
		rows_used = clamp_size(int'(rows_reg), MAX_ROWS_DEF);
		cols_used = clamp_size(int'(cols_reg), MAX_COLS_DEF);
		if (restart) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = (col_pos >= MAX_COLS_DEF) ? MAX_COLS_DEF - 1 : col_pos;
		column = {wall, logic'(newer_line[c]), logic'(older_line[c])};
		left = window_cols[2:0];
		centre = window_cols[5:3];
		hit = (r >= 2 && c >= 2);
		res = '0;
		if (hit) begin
			cnt = 0;
			for (int k = 0; k < 3; k++)
				cnt += int'(left[k]) + int'(centre[k]) + int'(column[k]);
			cnt -= int'(centre[1]);
			res.res_row = COORD_W'(r - 1);
			res.res_col = COORD_W'(c - 1);
			res.res_wall = (cnt <= int'(floor_most_reg) || cnt >= int'(floor_least_reg)) ?
				1'b0 : 1'b1;
			res.res_count = CNT_W'(cnt);
			res.res_last = (r == rows_used - 1 && c == cols_used - 1);
		end
		older_line[c] = newer_line[c];
		newer_line[c] = wall;
		window_cols = {column, centre};
		col_pos = col_pos + 1;
		if (col_pos >= cols_used) begin
			col_pos = 0;
			row_pos = row_pos + 1;
			if (row_pos >= rows_used)
				row_pos = 0;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_cell(input logic wall, input logic restart, input bit use_typed,
			input cell_result_t typed_res);
		int           gap;
		cell_result_t res;
		bit           hit;
		if (cells_sent >= QUIET_AFTER)
			idling_on = 1'b0;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cell_in <= wall;
		frame_start <= restart;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hit = smooth_cell(wall, restart, res);
		if (use_typed)
			pending_cells.push_back(typed_res);
		else if (hit)
			pending_cells.push_back(res);
		cells_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_GRID_ROWS:     rows_reg = data;
			CFG_GRID_COLS:     cols_reg = data;
			CFG_DEAD_AT_MOST:  floor_most_reg = data[THR_W-1:0];
			CFG_DEAD_AT_LEAST: floor_least_reg = data[THR_W-1:0];
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// border cells leave no result, so let the pipeline settle after the queue empties
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
			input logic [THR_W-1:0] most, input logic [THR_W-1:0] least);
		write_reg(CFG_GRID_ROWS, rows);
		write_reg(CFG_GRID_COLS, cols);
		write_reg(CFG_DEAD_AT_MOST, {3'($urandom_range(0, 7)), most});
		write_reg(CFG_DEAD_AT_LEAST, {3'($urandom_range(0, 7)), least});
		cfg_valid <= 1'b0;
		cols_in_use = clamp_size(int'(cols), MAX_COLS_DEF);
		phases_run++;
	endtask

	task automatic run_cells(input int count, input int density, input bit restart_first);
		logic wall;
		logic restart;
		for (int i = 0; i < count; i++) begin
			wall = ($urandom_range(0, 99) < density);
			restart = (i == 0 && restart_first) || ($urandom_range(0, 99) == 0);
			send_cell(wall, restart, 1'b0, NO_RES);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		cell_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", quiet_cycles);
				$display("** cave_automaton_smoothing_step: FAILED **");
				$finish;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_cells.size() == 0) begin
					report_mismatch("unexpected result, row", 8'(out_row), 8'd0);
				end else begin
					want = pending_cells.pop_front();
					if (out_row !== want.res_row)
						report_mismatch("out_row", 8'(out_row), 8'(want.res_row));
					if (out_col !== want.res_col)
						report_mismatch("out_col", 8'(out_col), 8'(want.res_col));
					if (new_cell !== want.res_wall)
						report_mismatch("new_cell", 8'(new_cell), 8'(want.res_wall));
					if (neighbour_count !== want.res_count)
						report_mismatch("neighbour_count", 8'(neighbour_count),
							8'(want.res_count));
					if (frame_last !== want.res_last)
						report_mismatch("frame_last", 8'(frame_last), 8'(want.res_last));
				end
			end
		end
	end

	initial begin
		int fixed_rows [3];
		int fixed_cols [3];
		int fixed_most [3];
		int fixed_least [3];
		int rows_raw;
		int cols_raw;
		int most;
		int least;
		int grid_cells;
		bit keep_position;

		// 3x3 grids: solid walls, solid floor following without a restart,
		// then two cells of a third grid that opens with a restart
		directed_rows = '{
			'{1'b1, 1'b1, 1'b0, NO_RES}, '{1'b1, 1'b0, 1'b0, NO_RES},
			'{1'b1, 1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, 1'b0, NO_RES},
			'{1'b1, 1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, 1'b0, NO_RES},
			'{1'b1, 1'b0, 1'b0, NO_RES}, '{1'b1, 1'b0, 1'b0, NO_RES},
			'{1'b1, 1'b0, 1'b1, ALL_WALL},
			'{1'b0, 1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, 1'b0, NO_RES},
			'{1'b0, 1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, 1'b0, NO_RES},
			'{1'b0, 1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, 1'b0, NO_RES},
			'{1'b0, 1'b0, 1'b0, NO_RES}, '{1'b0, 1'b0, 1'b0, NO_RES},
			'{1'b0, 1'b0, 1'b1, ALL_FLOOR},
			'{1'b1, 1'b1, 1'b0, NO_RES}, '{1'b0, 1'b0, 1'b0, NO_RES}
		};
		// sizes below 3 and above 64 clamp; thresholds at their extremes
		fixed_rows = '{1, 127, 2};
		fixed_cols = '{0, 2, 127};
		fixed_most = '{0, 8, 15};
		fixed_least = '{9, 15, 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(7'd3, 7'd3, DEAD_AT_MOST_RST, DEAD_AT_LEAST_RST);
		foreach (directed_rows[i])
			send_cell(directed_rows[i].wall, directed_rows[i].restart,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 3; p++) begin
			drain_results();
			configure(SIZE_W'(fixed_rows[p]), SIZE_W'(fixed_cols[p]),
				THR_W'(fixed_most[p]), THR_W'(fixed_least[p]));
			grid_cells = clamp_size(fixed_rows[p], MAX_ROWS_DEF) *
				clamp_size(fixed_cols[p], MAX_COLS_DEF);
			run_cells(grid_cells + (grid_cells < 20 ? grid_cells : 0),
				$urandom_range(30, 70), 1'b1);
		end

		while (cells_sent < CELL_TARGET) begin
			rows_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 8);
			cols_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 10);
			if ($urandom_range(0, 3) == 0) begin
				most = $urandom_range(0, 15);
				least = $urandom_range(0, 15);
			end else begin
				most = $urandom_range(1, 4);
				least = $urandom_range(5, 8);
			end
			// carry on mid grid only when the row gets no wider
			keep_position = (clamp_size(cols_raw, MAX_COLS_DEF) <= cols_in_use) &&
				($urandom_range(0, 2) == 0);
			grid_cells = clamp_size(rows_raw, MAX_ROWS_DEF) *
				clamp_size(cols_raw, MAX_COLS_DEF);
			drain_results();
			idling_on = (cells_sent < QUIET_AFTER) && ($urandom_range(0, 4) != 0);
			configure(SIZE_W'(rows_raw), SIZE_W'(cols_raw), THR_W'(most), THR_W'(least));
			run_cells($urandom_range(1, 3) * grid_cells + $urandom_range(0, grid_cells - 1),
				$urandom_range(15, 85), !keep_position);
		end

		drain_results();
		repeat (4) @(negedge clk);
		$display("run: %0d cells in %0d phases, %0d results checked, %0d register writes",
			cells_sent, phases_run, results_seen, reg_writes);
		$display("grids 3x3 to 64x64, restarts and narrowing mid grid, %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_cells.size() == 0)
			$display("** cave_automaton_smoothing_step: PASSED **");
		else
			$display("** cave_automaton_smoothing_step: FAILED **");
		$finish;
	end

endmodule

### filelist.f
src/cacss_pkg.sv
src/cacss_linebuf.sv
src/cacss_cell.sv
src/cave_automaton_smoothing_step.sv
src/cacss_check.sv
sim/cave_automaton_smoothing_step_tb.sv
